// ----- sv/rational_add_sub_reduce_defines.svh -----
// assertion macros for the rational add/subtract block
// expects clk and arst_n in the scope of every use
`ifndef RATIONAL_ADD_SUB_REDUCE_DEFINES_SVH
`define RATIONAL_ADD_SUB_REDUCE_DEFINES_SVH
`ifndef SYNTHESIS
`define RASR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RASR_NEVER(lbl, cond, msg) \
	`RASR_ASSERT(lbl, !(cond), msg)
`else
`define RASR_ASSERT(lbl, prop, msg)
`define RASR_NEVER(lbl, cond, msg)
`endif
`endif

// ----- sv/rasr_pkg.sv -----
// shared constants for the rational add/subtract block
// no dependencies
package rasr_pkg;
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int NUM_OUT_W = 32;
	localparam int DEN_OUT_W = 30;
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_SUB = 1'b1;
endpackage

// ----- sv/rasr_if.sv -----
// valid/ready channels for operand beats and result beats
// depends on rasr_pkg
interface rasr_in_if #(parameter int W = rasr_pkg::OPERAND_WIDTH_DEF);
	logic valid;
	logic ready;
	logic cmd;
	logic signed [W-1:0] num_a;
	logic [W-2:0] den_a;
	logic signed [W-1:0] num_b;
	logic [W-2:0] den_b;
	modport source(output valid, cmd, num_a, den_a, num_b, den_b, input ready);
	modport sink(input valid, cmd, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rasr_out_if;
	logic valid;
	logic ready;
	logic signed [rasr_pkg::NUM_OUT_W-1:0] num_out;
	logic [rasr_pkg::DEN_OUT_W-1:0] den_out;
	logic zero_den;
	modport source(output valid, num_out, den_out, zero_den, input ready);
	modport sink(input valid, num_out, den_out, zero_den, output ready);
endinterface

// ----- sv/rasr_front.sv -----
// front end: takes operand beats, flags zero denominators, packs a job
// depends on rasr_pkg and rasr_if
module rasr_front #(
	parameter int W = rasr_pkg::OPERAND_WIDTH_DEF,
	parameter int JOB_W = 4 * W
) (
	rasr_in_if.sink req,
	input logic full,
	output logic push,
	output logic [JOB_W-1:0] job
);
	logic zd;

	assign req.ready = !full;
	assign push = req.valid && !full;
	assign zd = (req.den_a == '0) || (req.den_b == '0);
	assign job = {zd, req.cmd, req.num_a, req.den_a, req.num_b, req.den_b};
endmodule

// ----- sv/rasr_fifo.sv -----
// two-entry job queue between front end and back end
// no package dependencies
module rasr_fifo #(
	parameter int DATA_W = 64
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [DATA_W-1:0] din,
	output logic full,
	input logic pop,
	output logic [DATA_W-1:0] dout,
	output logic empty
);
	localparam int DEPTH = 2;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ----- sv/rasr_back.sv -----
// back end: gcd, divide, scale, add and reduce sequencer with result register
// depends on rasr_pkg, rasr_if and rational_add_sub_reduce_defines.svh
`include "rational_add_sub_reduce_defines.svh"
module rasr_back #(
	parameter int W = rasr_pkg::OPERAND_WIDTH_DEF,
	parameter int JOB_W = 4 * W
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input logic [JOB_W-1:0] job,
	output logic pop,
	rasr_out_if.source rsp
);
	localparam int DNW = W - 1;
	localparam int DW = 2 * W;
	localparam int CW = $clog2(DW + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_GCD   = 9'b000000010,
		S_FIX   = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_MUL_L = 9'b000010000,
		S_MUL_A = 9'b000100000,
		S_MUL_B = 9'b001000000,
		S_SUM   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q;
	logic ph_q, zd_q, cmd_q, neg_q, ovalid_q, zd_out_q;
	logic signed [W-1:0] na_q, nb_q;
	logic [DNW-1:0] da_q, db_q;
	logic [DW-1:0] gx_q, gy_q, dv_q, lcm_q, mag_q;
	logic [CW-1:0] gk_q, cnt_q;
	logic [DW-1:0] dn_q [2];
	logic [DW-1:0] rem_q [2];
	logic signed [DW-1:0] ta_q, tb_q;
	logic signed [rasr_pkg::NUM_OUT_W-1:0] num_out_q;
	logic [rasr_pkg::DEN_OUT_W-1:0] den_out_q;

	logic j_zd, j_cmd;
	logic signed [W-1:0] j_na, j_nb;
	logic [DNW-1:0] j_da, j_db;
	logic [DW:0] tr [2];
	logic ge [2];
	logic [DW-1:0] rem_nx [2];
	logic [DW-1:0] dn_nx [2];
	logic signed [W-1:0] mul_a, mul_b;
	logic signed [DW-1:0] prod, sumv, snum;
	logic load_ok;

	assign {j_zd, j_cmd, j_na, j_da, j_nb, j_db} = job;
	assign pop = (state_q == S_IDLE) && job_valid;
	assign load_ok = !ovalid_q || rsp.ready;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			tr[i] = {rem_q[i], dn_q[i][DW-1]};
			ge[i] = tr[i] >= {1'b0, dv_q};
			rem_nx[i] = ge[i] ? DW'(tr[i] - {1'b0, dv_q}) : tr[i][DW-1:0];
			dn_nx[i] = {dn_q[i][DW-2:0], ge[i]};
		end
	end

	always_comb begin
		unique case (state_q)
			S_MUL_L: begin
				mul_a = $signed({1'b0, dn_q[0][DNW-1:0]});
				mul_b = $signed({1'b0, db_q});
			end
			S_MUL_A: begin
				mul_a = na_q;
				mul_b = $signed({1'b0, dn_q[1][DNW-1:0]});
			end
			default: begin
				mul_a = nb_q;
				mul_b = $signed({1'b0, dn_q[0][DNW-1:0]});
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign sumv = (cmd_q == rasr_pkg::CMD_SUB) ? (ta_q - tb_q) : (ta_q + tb_q);
	assign snum = neg_q ? -$signed(dn_q[0]) : $signed(dn_q[0]);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				zd_q <= j_zd;
				cmd_q <= j_cmd;
				na_q <= j_na;
				nb_q <= j_nb;
				da_q <= j_da;
				db_q <= j_db;
				gx_q <= DW'(j_da);
				gy_q <= DW'(j_db);
				gk_q <= '0;
			end
			S_GCD: begin
				priority if (gx_q == '0 || gy_q == '0) begin
					gx_q <= gx_q | gy_q;
				end else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					gk_q <= gk_q + 1'b1;
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else if (gx_q >= gy_q) begin
					gx_q <= gx_q - gy_q;
				end else begin
					gy_q <= gy_q - gx_q;
				end
			end
			S_FIX: begin
				if (gk_q == '0) begin
					dn_q[0] <= ph_q ? mag_q : DW'(da_q);
					dn_q[1] <= ph_q ? lcm_q : DW'(db_q);
					rem_q[0] <= '0;
					rem_q[1] <= '0;
					dv_q <= gx_q;
					cnt_q <= CW'(DW);
				end else begin
					gx_q <= gx_q << 1;
					gk_q <= gk_q - 1'b1;
				end
			end
			S_DIV: begin
				dn_q[0] <= dn_nx[0];
				dn_q[1] <= dn_nx[1];
				rem_q[0] <= rem_nx[0];
				rem_q[1] <= rem_nx[1];
				cnt_q <= cnt_q - 1'b1;
			end
			S_MUL_L: lcm_q <= DW'(prod);
			S_MUL_A: ta_q <= prod;
			S_MUL_B: tb_q <= prod;
			S_SUM: begin
				neg_q <= sumv[DW-1];
				mag_q <= sumv[DW-1] ? DW'(-sumv) : DW'(sumv);
				gx_q <= sumv[DW-1] ? DW'(-sumv) : DW'(sumv);
				gy_q <= lcm_q;
				gk_q <= '0;
			end
			S_OUT: begin
				if (load_ok) begin
					num_out_q <= zd_q ? '0 : rasr_pkg::NUM_OUT_W'(snum);
					den_out_q <= zd_q ? rasr_pkg::DEN_OUT_W'(1) : rasr_pkg::DEN_OUT_W'(dn_q[1]);
					zd_out_q <= zd_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && load_ok) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						ph_q <= 1'b0;
						state_q <= j_zd ? S_OUT : S_GCD;
					end
				end
				S_GCD: begin
					if (gx_q == '0 || gy_q == '0) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					if (gk_q == '0) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == CW'(1)) begin
						state_q <= ph_q ? S_OUT : S_MUL_L;
					end
				end
				S_MUL_L: state_q <= S_MUL_A;
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_SUM;
				S_SUM: begin
					ph_q <= 1'b1;
					state_q <= S_GCD;
				end
				S_OUT: begin
					if (load_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = ovalid_q;
	assign rsp.num_out = num_out_q;
	assign rsp.den_out = den_out_q;
	assign rsp.zero_den = zd_out_q;

	`RASR_NEVER(a_div_by_zero, (state_q == S_DIV) && (dv_q == '0), "divide by zero divisor")
	`RASR_ASSERT(a_zero_den_gives_zero, (ovalid_q && zd_out_q) |-> ((num_out_q == '0) && (den_out_q == rasr_pkg::DEN_OUT_W'(1))), "zero denominator result not 0/1")
	`RASR_ASSERT(a_result_from_out, $rose(ovalid_q) |-> $past(state_q == S_OUT), "result loaded outside output step")
endmodule

// ----- sv/rational_add_sub_reduce.sv -----
// Adds or subtracts two fractions and returns the result reduced to lowest terms, one result
// beat per operand beat. The back end runs two binary gcd passes in one shared gcd unit (one
// step per cycle), two passes of a shared two-lane restoring divider, and one shared multiplier
// for the lcm and both scaled numerators; a zero denominator goes straight to the output step,
// and a result may wait for the result register to drain. A two-entry queue lets the front end
// take beats while the back end works. Zero denominators give 0/1 with zero_den set. Numerator
// and denominator outputs are the low bits of the exact result.
// depends on rasr_pkg, rasr_if, rasr_front, rasr_fifo, rasr_back
module rational_add_sub_reduce #(
	parameter int OPERAND_WIDTH = rasr_pkg::OPERAND_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	rasr_in_if.sink req,
	rasr_out_if.source rsp
);
	localparam int JOB_W = 4 * OPERAND_WIDTH;

	logic push, full, empty, pop;
	logic [JOB_W-1:0] job_in, job_out;

	rasr_front #(.W(OPERAND_WIDTH), .JOB_W(JOB_W)) u_front (
		.req(req),
		.full(full),
		.push(push),
		.job(job_in)
	);

	rasr_fifo #(.DATA_W(JOB_W)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(job_in),
		.full(full),
		.pop(pop),
		.dout(job_out),
		.empty(empty)
	);

	rasr_back #(.W(OPERAND_WIDTH), .JOB_W(JOB_W)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(!empty),
		.job(job_out),
		.pop(pop),
		.rsp(rsp)
	);
endmodule
